@@ hdl/lhm_pkg.sv @@
package lhm_pkg;

  localparam int TABLE_SIZE_DEF = 256;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 3;
  localparam int SLOT_W = 8;

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // slot marks
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  // result status codes
  localparam logic [STS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STS_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STS_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STS_W-1:0] ST_REMOVED  = 3'd4;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] found_value;
    logic [SLOT_W-1:0]       slot;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic load;
    logic probe;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic hit;
    logic empty;
    logic lap_end;
  } sts_t;

endpackage

@@ hdl/lhm_ctrl.sv @@
module lhm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lhm_pkg::cmd_t cmd,
  input  lhm_pkg::sts_t sts
);
  import lhm_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.hit || sts.empty || sts.lap_end) state_next = S_DONE;
      end
      S_DONE: begin
        // hold the outcome until the output register can take it
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/lhm_dp.sv @@
module lhm_dp #(
  parameter int TABLE_SIZE = lhm_pkg::TABLE_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lhm_pkg::req_t  req_data,
  input  lhm_pkg::cmd_t  cmd,
  output lhm_pkg::sts_t  sts,
  output lhm_pkg::rsp_t  rsp_data
);
  import lhm_pkg::*;

  localparam int IDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam bit POW2      = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam int DIG_W     = 4;
  localparam int SR_W      = 32;
  localparam int MOD_STEPS = SR_W / DIG_W;
  localparam int CNT_W     = $clog2(MOD_STEPS + 1);
  localparam int EXT_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W:0]   MODULUS = (IDX_W + 1)'(TABLE_SIZE);

  logic [KEY_W-1:0] key_mem  [TABLE_SIZE];
  logic [VAL_W-1:0] val_mem  [TABLE_SIZE];
  logic [1:0]       mark_mem [TABLE_SIZE];

  req_t             req;
  logic [SR_W-1:0]  dig_sr;
  logic [IDX_W-1:0] rem, rem_next, r_acc;
  logic [IDX_W:0]   t_acc;
  logic [CNT_W-1:0] mod_cnt;
  logic [IDX_W-1:0] home;

  logic [IDX_W-1:0] addr, addr_inc, count, clr_idx, rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [1:0]       rd_mark;
  logic             stop, step;

  logic             found, have_free;
  logic [IDX_W-1:0] hit_slot, free_slot;
  logic [VAL_W-1:0] hit_val;

  logic             key_we, val_we, mark_we;
  logic [IDX_W-1:0] wr_idx, res_idx;
  logic [1:0]       mark_wd;
  logic [STS_W-1:0] res_status;
  logic [VAL_W-1:0] res_value;
  logic [EXT_W-1:0] res_ext;

  // home slot: key mod table size; for a size that is not a power of two, four key bits per cycle, msb first
  always_comb begin
    r_acc = rem;
    t_acc = '0;
    for (int i = 0; i < DIG_W; i++) begin
      t_acc = {r_acc, dig_sr[SR_W-1-i]};
      if (t_acc >= MODULUS) t_acc = t_acc - MODULUS;
      r_acc = t_acc[IDX_W-1:0];
    end
    rem_next = r_acc;
  end

  assign home = POW2 ? IDX_W'(req.key) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (cmd.accept) begin
      req     <= req_data;
      dig_sr  <= SR_W'(req_data.key);
      rem     <= '0;
      mod_cnt <= POW2 ? '0 : CNT_W'(MOD_STEPS);
    end else if (mod_cnt != '0) begin
      rem     <= rem_next;
      dig_sr  <= dig_sr << DIG_W;
      mod_cnt <= mod_cnt - 1'b1;
    end
  end

  // probe walk: one slot a cycle, read data registered
  assign addr_inc = (addr == LAST) ? '0 : addr + 1'b1;
  assign sts.hit  = (rd_mark == MARK_USED) && (rd_key == req.key);
  assign sts.empty      = (rd_mark == MARK_EMPTY);
  assign sts.lap_end    = (count == LAST);
  assign sts.clear_last = (clr_idx == LAST);
  assign sts.mod_done   = (mod_cnt == '0);
  assign stop    = sts.hit || sts.empty || sts.lap_end;
  assign step    = cmd.probe && !stop;
  assign rd_addr = cmd.load ? home : (step ? addr_inc : addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + 1'b1;
      if (cmd.load) begin
        addr      <= home;
        count     <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
      end else if (cmd.probe) begin
        if (step) begin
          addr  <= addr_inc;
          count <= count + 1'b1;
        end
        if (sts.hit) begin
          found    <= 1'b1;
          hit_slot <= addr;
          hit_val  <= rd_val;
        end else if (rd_mark != MARK_USED && !have_free) begin
          // first deleted slot, or the empty slot ending the run
          have_free <= 1'b1;
          free_slot <= addr;
        end
      end
    end
  end

  // outcome and table update
  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    mark_we    = 1'b0;
    wr_idx     = hit_slot;
    mark_wd    = MARK_USED;
    res_status = ST_MISSING;
    res_value  = '0;
    res_idx    = '0;
    unique case (req.opcode)
      OP_INSERT: begin
        if (found) begin
          val_we     = 1'b1;
          res_status = ST_UPDATED;
          res_idx    = hit_slot;
        end else if (have_free) begin
          key_we     = 1'b1;
          val_we     = 1'b1;
          mark_we    = 1'b1;
          wr_idx     = free_slot;
          res_status = ST_INSERTED;
          res_idx    = free_slot;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_SEARCH: begin
        if (found) begin
          res_status = ST_FOUND;
          res_value  = hit_val;
          res_idx    = hit_slot;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          mark_we    = 1'b1;
          mark_wd    = MARK_DELETED;
          res_status = ST_REMOVED;
          res_idx    = hit_slot;
        end
      end
      default: ;
    endcase
  end

  assign res_ext = EXT_W'(res_idx);

  always_ff @(posedge clk) begin
    if (cmd.commit && key_we) key_mem[wr_idx] <= req.key;
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && val_we) val_mem[wr_idx] <= req.value;
    rd_val <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mark_mem[clr_idx] <= MARK_EMPTY;
    end else if (cmd.commit && mark_we) begin
      mark_mem[wr_idx] <= mark_wd;
    end
    rd_mark <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data.status      <= res_status;
      rsp_data.found_value <= res_value;
      rsp_data.slot        <= res_ext[SLOT_W-1:0];
    end
  end

endmodule

@@ hdl/linear_probe_hash_map.sv @@
// Key/value store over TABLE_SIZE slots, open addressing with linear probing.
// Request channel (req_valid/req_stall/req_data): one insert, search or remove
// per transfer. Response channel (rsp_valid/rsp_stall/rsp_data): exactly one
// result per request, in request order.
// The home slot is key mod TABLE_SIZE: the low key bits for a power-of-two
// size, otherwise the output of a remainder unit fed four key bits at a time.
// The probe then reads one slot per cycle from the slot memories until a key
// match, an empty slot or a full lap. One request is in work at a time: the
// next request is taken only after the result of the last one has been
// committed to the output register.
// Removed slots are marked deleted so later probe runs pass through them.
// After reset the slot marks are swept to empty with req_stall high. A stalled
// response stays in the output register; the next request is still taken and
// its result waits until the register frees.
module linear_probe_hash_map #(
  parameter int TABLE_SIZE = lhm_pkg::TABLE_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lhm_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lhm_pkg::rsp_t rsp_data
);
  import lhm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lhm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lhm_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_data (rsp_data)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous one still in work");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.status <= ST_FULL))
    else $error("response status code out of range");

  a_value_only_on_found: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != ST_FOUND) |-> (rsp_data.found_value == '0))
    else $error("found_value nonzero without a successful search");

  a_no_slot_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.status == ST_MISSING || rsp_data.status == ST_FULL))
      |-> (rsp_data.slot == '0))
    else $error("slot nonzero on a miss or full table");
`endif

endmodule
